// File: hdl/rbf_pkg.sv
// Shared types and constants of the three-axis rate band-pass filter.
package rbf_pkg;

    localparam int RAW_W   = 16;
    localparam int SCALE_W = 24;
    localparam int COEF_W  = 32;
    localparam int HIST_W  = 48;
    localparam int RATE_W  = 40;
    localparam int S_W     = 33;
    localparam int PL_W    = 65;
    localparam int PH_W    = 48;
    localparam int ACC_W   = 83;
    localparam int FRAC_SH = 28;
    localparam int DIFF_W  = 50;
    localparam int SUM_W   = 51;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register indexes on the configuration port (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_SCALE_RECIP = 3'd0,
        REG_COEF_INPUT  = 3'd1,
        REG_COEF_OLDEST = 3'd2,
        REG_COEF_THIRD  = 3'd3,
        REG_COEF_SECOND = 3'd4,
        REG_COEF_NEWEST = 3'd5
    } reg_idx_t;

    localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd255984;
    localparam logic [COEF_W-1:0]  INPUT_RESET  = 32'sd18260584;
    localparam logic [COEF_W-1:0]  OLDEST_RESET = -32'sd111778168;
    localparam logic [COEF_W-1:0]  THIRD_RESET  = 32'sd531467613;
    localparam logic [COEF_W-1:0]  SECOND_RESET = -32'sd995400053;
    localparam logic [COEF_W-1:0]  NEWEST_RESET = 32'sd844143196;

    // Term fed to the lane multipliers in a given step of the sum.
    typedef enum logic [2:0] {
        SEL_OLDEST = 3'd0,
        SEL_THIRD  = 3'd1,
        SEL_SECOND = 3'd2,
        SEL_NEWEST = 3'd3,
        SEL_INPUT  = 3'd4
    } term_sel_t;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        term_sel_t sel;
        logic      acc_en;
        logic      fin;
    } lane_ctrl_t;

endpackage

// File: hdl/rbf_lane.sv
// One axis of the filter: input scaling, split multiply-accumulate, history and result.
module rbf_lane
    import rbf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lane_ctrl_t                  ctrl,
    input  logic signed [RAW_W-1:0]     raw,
    input  logic [SCALE_W-1:0]          scale_recip,
    input  logic signed [COEF_W-1:0]    coef,
    output logic signed [RATE_W-1:0]    rate
);

    localparam logic signed [HIST_W-1:0] HMAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] HMIN = {1'b1, {(HIST_W-1){1'b0}}};
    localparam logic signed [RATE_W-1:0] RMAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RMIN = {1'b1, {(RATE_W-1){1'b0}}};

    logic signed [HIST_W-1:0]      hist_reg [4];
    logic signed [RAW_W+SCALE_W:0] sprod_reg;
    logic signed [S_W-1:0]         s_reg;
    logic signed [PL_W-1:0]        pl_reg;
    logic signed [PH_W-1:0]        ph_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [HIST_W-1:0]      nv_reg;

    logic signed [RAW_W+SCALE_W:0] s_round;
    logic signed [HIST_W-1:0]      op;
    logic signed [ACC_W-1:0]       term;
    logic signed [ACC_W-1:0]       rsum;
    logic signed [ACC_W-FRAC_SH-1:0] sh;
    logic signed [HIST_W-1:0]      nv_next;
    logic signed [SUM_W-1:0]       r;

    assign s_round = sprod_reg + (RAW_W+SCALE_W+1)'(128);

    always_comb
    begin
        case (ctrl.sel)
            SEL_OLDEST: op = hist_reg[0];
            SEL_THIRD:  op = hist_reg[1];
            SEL_SECOND: op = hist_reg[2];
            SEL_NEWEST: op = hist_reg[3];
            SEL_INPUT:  op = {{(HIST_W-S_W){s_reg[S_W-1]}}, s_reg};
            default:    op = '0;
        endcase
    end

    // The 48-bit operand is split into an unsigned low word and a signed high part.
    assign term = {{(ACC_W-PL_W){pl_reg[PL_W-1]}}, pl_reg}
                + {{(ACC_W-PH_W-32){ph_reg[PH_W-1]}}, ph_reg, 32'd0};

    assign rsum = acc_reg + ACC_W'(1 << (FRAC_SH-1));
    assign sh   = rsum[ACC_W-1:FRAC_SH];

    always_comb
    begin
        if (&sh[ACC_W-FRAC_SH-1:HIST_W-1] || ~|sh[ACC_W-FRAC_SH-1:HIST_W-1])
            nv_next = sh[HIST_W-1:0];
        else if (sh[ACC_W-FRAC_SH-1])
            nv_next = HMIN;
        else
            nv_next = HMAX;
    end

    assign r = SUM_W'(diff_reg) + SUM_W'(nv_reg);

    always_comb
    begin
        if (&r[SUM_W-1:RATE_W-1] || ~|r[SUM_W-1:RATE_W-1])
            rate = r[RATE_W-1:0];
        else if (r[SUM_W-1])
            rate = RMIN;
        else
            rate = RMAX;
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_round[RAW_W+SCALE_W:8];
        if (ctrl.load)
        begin
            sprod_reg <= raw * $signed({1'b0, scale_recip});
            diff_reg  <= DIFF_W'(hist_reg[0]) - (DIFF_W'(hist_reg[2]) <<< 1);
            acc_reg   <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + term;
        end
        if (ctrl.mul_en)
        begin
            pl_reg <= coef * $signed({1'b0, op[31:0]});
            ph_reg <= coef * $signed(op[HIST_W-1:32]);
        end
        if (ctrl.fin)
        begin
            nv_reg <= nv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctrl.fin)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= hist_reg[3];
            hist_reg[3] <= nv_next;
        end
    end

endmodule

// File: hdl/rbf_merge.sv
// Output register that gathers the lane results into one item.
module rbf_merge
    import rbf_pkg::*;
#(
    parameter int AXES = 3
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [AXES-1:0][RATE_W-1:0]       lane_rate,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [AXES*RATE_W-1:0]            m_tdata
);

    logic                       valid_reg;
    logic [AXES*RATE_W-1:0]     data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= lane_rate;
        end
    end

endmodule

// File: hdl/three_axis_rate_bandpass_filter.sv
// Top level of the three-axis gyro rate band-pass filter.
//
// Each input item on the s_ stream carries three raw gyro samples. Raw x and y
// are swapped, each sample is scaled to Q16.16, and one lane per axis runs a
// fourth-order recursive section and delivers a saturated Q23.16 rate.
// One result item leaves on the m_ stream for every input item.
// The lanes work side by side; each has one 32x33 and one 32x16 multiplier
// that together form one coefficient-times-operand product per cycle.
// Five products per item: after the edge that accepts the item the sequencer runs
// its multiply state for each product, then a state that adds the last product,
// one that rounds and saturates the new state, and one that hands the result to
// the output register, which then shows it on m_tvalid. An item is taken only in
// the idle state, so the block does not accept a new item before the last one
// has been handed to the output register.
// The output register lets the next item be accepted while a finished result
// still waits for m_tready; a stalled receiver holds the block in its hand-off
// step once the next result is ready, and s_tready stays low until then.
// Reset clears the filter history to zero, empties the output register and
// loads the default scale and coefficients. Registers are written through the APB port
// and the user must write them only while the block is idle; the block does not enforce it.
module three_axis_rate_bandpass_filter
    import rbf_pkg::*;
#(
    parameter int AXES = 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [47:0]               s_tdata,   // raw_x, raw_y, raw_z
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [AXES*RATE_W-1:0]    m_tdata,   // rate_x, rate_y, rate_z, further axes
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LAST,
        ST_FIN,
        ST_PUSH
    } state_t;

    state_t     state_reg, state_next;
    term_sel_t  cnt_reg, cnt_next;

    logic [SCALE_W-1:0] scale_reg;
    logic [COEF_W-1:0]  c_input_reg, c_oldest_reg, c_third_reg, c_second_reg, c_newest_reg;

    logic                      accept;
    logic                      push;
    logic                      free;
    logic                      wr_en;
    reg_idx_t                  widx;
    lane_ctrl_t                ctrl;
    logic signed [COEF_W-1:0]  coef;
    logic [AXES-1:0][RATE_W-1:0] lane_rate;

    // Configuration port: always ready, written in the access phase.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_RESET;
            c_input_reg  <= INPUT_RESET;
            c_oldest_reg <= OLDEST_RESET;
            c_third_reg  <= THIRD_RESET;
            c_second_reg <= SECOND_RESET;
            c_newest_reg <= NEWEST_RESET;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_SCALE_RECIP: scale_reg    <= pwdata[SCALE_W-1:0];
                REG_COEF_INPUT:  c_input_reg  <= pwdata;
                REG_COEF_OLDEST: c_oldest_reg <= pwdata;
                REG_COEF_THIRD:  c_third_reg  <= pwdata;
                REG_COEF_SECOND: c_second_reg <= pwdata;
                REG_COEF_NEWEST: c_newest_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_SCALE_RECIP: prdata = {{(DATA_W-SCALE_W){1'b0}}, scale_reg};
            REG_COEF_INPUT:  prdata = c_input_reg;
            REG_COEF_OLDEST: prdata = c_oldest_reg;
            REG_COEF_THIRD:  prdata = c_third_reg;
            REG_COEF_SECOND: prdata = c_second_reg;
            REG_COEF_NEWEST: prdata = c_newest_reg;
            default:         prdata = '0;
        endcase
    end

    // Sequencer shared by all lanes.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg == ST_PUSH) && free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                    cnt_next   = SEL_OLDEST;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == SEL_INPUT)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    cnt_next = term_sel_t'(cnt_reg + 3'd1);
                end
            end
            ST_LAST: state_next = ST_FIN;
            ST_FIN:  state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= SEL_OLDEST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        ctrl.load   = accept;
        ctrl.mul_en = (state_reg == ST_MUL);
        ctrl.sel    = cnt_reg;
        ctrl.acc_en = ((state_reg == ST_MUL) && (cnt_reg != SEL_OLDEST))
                      || (state_reg == ST_LAST);
        ctrl.fin    = (state_reg == ST_FIN);
    end

    always_comb
    begin
        case (cnt_reg)
            SEL_OLDEST: coef = c_oldest_reg;
            SEL_THIRD:  coef = c_third_reg;
            SEL_SECOND: coef = c_second_reg;
            SEL_NEWEST: coef = c_newest_reg;
            SEL_INPUT:  coef = c_input_reg;
            default:    coef = '0;
        endcase
    end

    // Lane k filters raw y for k = 0, raw x for k = 1, raw z for k = 2; further lanes see zero.
    for (genvar k = 0; k < AXES; k++)
    begin : g_lane
        logic signed [RAW_W-1:0] raw;
        if (k == 0)
        begin : g_y
            assign raw = s_tdata[31:16];
        end
        else if (k == 1)
        begin : g_x
            assign raw = s_tdata[15:0];
        end
        else if (k == 2)
        begin : g_z
            assign raw = s_tdata[47:32];
        end
        else
        begin : g_none
            assign raw = '0;
        end

        rbf_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .raw         (raw),
            .scale_recip (scale_reg),
            .coef        (coef),
            .rate        (lane_rate[k])
        );
    end

    rbf_merge #(
        .AXES (AXES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .lane_rate (lane_rate),
        .free      (free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MUL) && (cnt_reg == SEL_OLDEST))
        else $error("accepted item did not start the multiply sequence");

    a_fin_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST) |=> (state_reg == ST_FIN))
        else $error("state update did not follow the last product");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> m_tvalid)
        else $error("handed-off result not presented on the output");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept)
        else $error("item accepted while a previous one is in progress");
`endif

endmodule
